### design/gtlp_pkg.sv
// ----------------------------------------------------------------------------
// gtlp_pkg
// Shared types, codes and the control program of the glyph row generator.
// ----------------------------------------------------------------------------
`default_nettype none

package gtlp_pkg;

  // Default geometry of the font
  localparam int DEF_GLYPH_ROWS  = 14;
  localparam int DEF_GLYPH_COLS  = 8;
  localparam int DEF_GLYPH_COUNT = 96;

  localparam int FIRST_CODE = 32;
  localparam int NUM_PIXELS = 8;

  // Input command codes (tuser on the slave side)
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  // Result kinds (tuser on the master side)
  localparam logic [1:0] KIND_REG   = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_ROW   = 2'd2;

  // Configuration register indexes
  localparam logic CFG_TEXT_COLOR = 1'b0;
  localparam logic CFG_BACK_COLOR = 1'b1;

  // Display controller registers and values
  localparam logic [7:0]  REG_ENTRY_MODE = 8'h05;
  localparam logic [7:0]  REG_WIN_A      = 8'h17;
  localparam logic [7:0]  REG_WIN_B      = 8'h16;
  localparam logic [7:0]  REG_CURSOR     = 8'h21;
  localparam logic [7:0]  REG_GRAM       = 8'h22;
  localparam logic [15:0] ENTRY_NORMAL   = 16'h0038;
  localparam logic [15:0] ENTRY_ROTATED  = 16'h0030;

  // Register write selector of a control word
  localparam logic [2:0] RSEL_NONE   = 3'd0;
  localparam logic [2:0] RSEL_ENTRY  = 3'd1;
  localparam logic [2:0] RSEL_WIN_X  = 3'd2;
  localparam logic [2:0] RSEL_WIN_Y  = 3'd3;
  localparam logic [2:0] RSEL_CURSOR = 3'd4;
  localparam logic [2:0] RSEL_GRAM   = 3'd5;

  // Sequencer operations
  localparam logic [1:0] SEQ_FETCH = 2'd0; // wait for a command
  localparam logic [1:0] SEQ_NEXT  = 2'd1; // advance once the result is out
  localparam logic [1:0] SEQ_ROWS  = 2'd2; // repeat over glyph rows
  localparam logic [1:0] SEQ_JUMP  = 2'd3; // unconditional jump

  localparam int STEP_W = 3;

  localparam logic [STEP_W-1:0] STEP_FETCH  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_ENTRY  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_WIN_X  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_WIN_Y  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_CURSOR = 3'd4;
  localparam logic [STEP_W-1:0] STEP_GRAM   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_ROWS   = 3'd6;

  typedef struct packed {
    logic              emit;
    logic [1:0]        kind;
    logic [2:0]        rsel;
    logic [1:0]        seq_op;
    logic [STEP_W-1:0] target;
  } uc_word_t;

  typedef struct packed {
    uc_word_t uc;
    logic     ready;  // slave side may transfer
    logic     take;   // input transaction this cycle
    logic     fire;   // load the output register this cycle
    logic     last;   // current result closes a character
  } seq_ctl_t;

  // Control program
  function automatic uc_word_t uc_rom(input logic [STEP_W-1:0] step);
    uc_word_t w;
    unique case (step)
      STEP_FETCH:  w = '{1'b0, KIND_REG,   RSEL_NONE,   SEQ_FETCH, STEP_ENTRY};
      STEP_ENTRY:  w = '{1'b1, KIND_REG,   RSEL_ENTRY,  SEQ_NEXT,  STEP_FETCH};
      STEP_WIN_X:  w = '{1'b1, KIND_REG,   RSEL_WIN_X,  SEQ_NEXT,  STEP_FETCH};
      STEP_WIN_Y:  w = '{1'b1, KIND_REG,   RSEL_WIN_Y,  SEQ_NEXT,  STEP_FETCH};
      STEP_CURSOR: w = '{1'b1, KIND_REG,   RSEL_CURSOR, SEQ_NEXT,  STEP_FETCH};
      STEP_GRAM:   w = '{1'b1, KIND_START, RSEL_GRAM,   SEQ_NEXT,  STEP_FETCH};
      STEP_ROWS:   w = '{1'b1, KIND_ROW,   RSEL_NONE,   SEQ_ROWS,  STEP_FETCH};
      default:     w = '{1'b0, KIND_REG,   RSEL_NONE,   SEQ_JUMP,  STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### design/gtlp_font_mem.sv
// ----------------------------------------------------------------------------
// gtlp_font_mem
// Font store: one glyph row per entry, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gtlp_font_mem #(
  parameter int DEPTH  = 1344,
  parameter int ADDR_W = 11
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/gtlp_sequencer.sv
// ----------------------------------------------------------------------------
// gtlp_sequencer
// Step counter over the control program, with the glyph row loop counter.
// ----------------------------------------------------------------------------
`default_nettype none

module gtlp_sequencer
  import gtlp_pkg::*;
#(
  parameter int GLYPH_ROWS = DEF_GLYPH_ROWS,
  localparam int ROW_W     = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_command,
  input  wire logic             out_free,
  output seq_ctl_t              ctl,
  output logic      [ROW_W-1:0] row_next
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [ROW_W-1:0]  row;
  uc_word_t          uc;
  logic              row_last;

  assign uc       = uc_rom(step);
  assign row_last = (row == ROW_W'(GLYPH_ROWS - 1));

  always_comb begin
    ctl.uc    = uc;
    ctl.ready = (uc.seq_op == SEQ_FETCH);
    ctl.take  = ctl.ready && in_valid;
    ctl.fire  = uc.emit && out_free;
    ctl.last  = (uc.seq_op == SEQ_ROWS) && row_last;
  end

  always_comb begin
    step_next = step;
    row_next  = row;
    unique case (uc.seq_op)
      SEQ_FETCH: begin
        row_next = '0;
        if (ctl.take && in_command == CMD_DRAW) begin
          step_next = uc.target;
        end
      end
      SEQ_NEXT: begin
        if (ctl.fire) begin
          step_next = step + STEP_W'(1);
        end
      end
      SEQ_ROWS: begin
        if (ctl.fire) begin
          if (row_last) begin
            step_next = uc.target;
          end else begin
            row_next = row + ROW_W'(1);
          end
        end
      end
      default: begin
        step_next = uc.target;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_FETCH;
      row  <= '0;
    end else begin
      step <= step_next;
      row  <= row_next;
    end
  end

endmodule

`default_nettype wire

### design/gtlp_datapath.sv
// ----------------------------------------------------------------------------
// gtlp_datapath
// Operand registers, font store access, color registers and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gtlp_datapath
  import gtlp_pkg::*;
#(
  parameter int GLYPH_ROWS  = DEF_GLYPH_ROWS,
  parameter int GLYPH_COLS  = DEF_GLYPH_COLS,
  parameter int GLYPH_COUNT = DEF_GLYPH_COUNT,
  localparam int ROW_W      = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire seq_ctl_t                          ctl,
  input  wire logic [ROW_W-1:0]                  row_next,
  input  wire logic                              command,
  input  wire logic [7:0]                        char_code,
  input  wire logic [3:0]                        row_index,
  input  wire logic [7:0]                        row_bits,
  input  wire logic [7:0]                        pos_x,
  input  wire logic [7:0]                        pos_y,
  input  wire logic                              rotation,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [15:0]                       cfg_data,
  input  wire logic                              out_ready,
  output logic                                   out_free,
  output logic                                   out_valid,
  output logic      [1:0]                        kind,
  output logic      [7:0]                        reg_address,
  output logic      [15:0]                       reg_value,
  output logic      [NUM_PIXELS-1:0][15:0]       pixels,
  output logic                                   last
);

  localparam int DEPTH   = GLYPH_COUNT * GLYPH_ROWS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int GLYPH_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  logic [15:0]        text_color;
  logic [15:0]        back_color;
  logic [7:0]         x;
  logic [7:0]         y;
  logic               rot;
  logic               glyph_ok;
  logic [ADDR_W-1:0]  base;
  logic [ADDR_W-1:0]  base_next;

  logic [7:0]         code_off;
  logic               code_ok;
  logic               row_ok;
  logic [GLYPH_W-1:0] glyph_in;
  logic [ADDR_W-1:0]  glyph_base;
  logic               mem_we;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr;
  logic [7:0]         rdata;
  logic [7:0]         line;

  logic [7:0]                  addr_d;
  logic [15:0]                 value_d;
  logic [NUM_PIXELS-1:0][15:0] row_pix;

  // Glyph index and store address of the incoming item
  assign code_off   = char_code - 8'(FIRST_CODE);
  assign code_ok    = (char_code >= 8'(FIRST_CODE)) && ({1'b0, code_off} < 9'(GLYPH_COUNT));
  assign row_ok     = {1'b0, row_index} < 5'(GLYPH_ROWS);
  assign glyph_in   = code_ok ? GLYPH_W'(code_off) : '0;
  assign glyph_base = ADDR_W'(glyph_in) * ADDR_W'(GLYPH_ROWS);

  assign mem_we    = ctl.take && command == CMD_LOAD && code_ok && row_ok;
  assign waddr     = glyph_base + ADDR_W'(row_index);
  assign base_next = (ctl.take && command == CMD_DRAW) ? glyph_base : base;
  // Read ahead with the next row so the data lines up with the row counter
  assign raddr     = base_next + ADDR_W'(row_next);

  gtlp_font_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_font_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (row_bits),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    base <= base_next;
    if (ctl.take && command == CMD_DRAW) begin
      x        <= pos_x;
      y        <= pos_y;
      rot      <= rotation;
      glyph_ok <= code_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= 16'h0000;
      back_color <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEXT_COLOR: text_color <= cfg_data;
        CFG_BACK_COLOR: back_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // Codes outside the font draw background only
  assign line = glyph_ok ? rdata : 8'h00;

  for (genvar p = 0; p < NUM_PIXELS; p++) begin : g_pix
    if (p < GLYPH_COLS) begin : g_on
      assign row_pix[p] = line[7-p] ? text_color : back_color;
    end else begin : g_off
      assign row_pix[p] = 16'h0000;
    end
  end

  always_comb begin
    addr_d  = 8'h00;
    value_d = 16'h0000;
    unique case (ctl.uc.rsel)
      RSEL_ENTRY: begin
        addr_d  = REG_ENTRY_MODE;
        value_d = rot ? ENTRY_ROTATED : ENTRY_NORMAL;
      end
      RSEL_WIN_X: begin
        addr_d  = rot ? REG_WIN_B : REG_WIN_A;
        value_d = {x + 8'(GLYPH_COLS - 1), x};
      end
      RSEL_WIN_Y: begin
        addr_d  = rot ? REG_WIN_A : REG_WIN_B;
        value_d = {y + 8'(GLYPH_ROWS - 1), y};
      end
      RSEL_CURSOR: begin
        addr_d  = REG_CURSOR;
        value_d = rot ? {y, x} : {x, y};
      end
      RSEL_GRAM: begin
        addr_d = REG_GRAM;
      end
      default: ;
    endcase
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      kind        <= ctl.uc.kind;
      reg_address <= addr_d;
      reg_value   <= value_d;
      pixels      <= (ctl.uc.kind == KIND_ROW) ? row_pix : '0;
      last        <= ctl.last;
    end
  end

endmodule

`default_nettype wire

### design/glyph_to_lcd_pixel_rows.sv
// ----------------------------------------------------------------------------
// glyph_to_lcd_pixel_rows
// Bitmap font character generator for a 16-bit-color LCD controller.
// ----------------------------------------------------------------------------
// A load command (tuser 0) writes one glyph row into the font store. A draw
// command (tuser 1) produces GLYPH_ROWS + 5 results: entry mode, two window
// writes, cursor, the pixel data start marker and one result per glyph row.
// After the command is taken the results come out one per cycle while the
// master side is free, paced by the step counter of the control program,
// whose row loop reads one font store row per cycle. Rows of a code whose
// glyph was never loaded come out undefined. No clearing pass is run.
`default_nettype none

module glyph_to_lcd_pixel_rows
  import gtlp_pkg::*;
#(
  parameter int GLYPH_ROWS  = DEF_GLYPH_ROWS,
  parameter int GLYPH_COLS  = DEF_GLYPH_COLS,
  parameter int GLYPH_COUNT = DEF_GLYPH_COUNT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // char_code[7:0], row_index[11:8], row_bits[19:12], pos_x[27:20],
  // pos_y[35:28], rotation[36], zero[39:37]
  input  wire logic [39:0]  s_axis_tdata,
  // command[0]
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // reg_address[7:0], reg_value[23:8], pixel_0[39:24] .. pixel_7[151:136]
  output logic      [151:0] m_axis_tdata,
  // kind[1:0]
  output logic      [1:0]   m_axis_tuser,
  output logic              m_axis_tlast,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [15:0]  cfg_data
);

  localparam int ROW_W = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

  seq_ctl_t                    ctl;
  logic [ROW_W-1:0]            row_next;
  logic                        out_free;
  logic [7:0]                  reg_address;
  logic [15:0]                 reg_value;
  logic [NUM_PIXELS-1:0][15:0] pixels;

  gtlp_sequencer #(
    .GLYPH_ROWS (GLYPH_ROWS)
  ) u_sequencer (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_command (s_axis_tuser),
    .out_free   (out_free),
    .ctl        (ctl),
    .row_next   (row_next)
  );

  gtlp_datapath #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COLS  (GLYPH_COLS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .row_next    (row_next),
    .command     (s_axis_tuser),
    .char_code   (s_axis_tdata[7:0]),
    .row_index   (s_axis_tdata[11:8]),
    .row_bits    (s_axis_tdata[19:12]),
    .pos_x       (s_axis_tdata[27:20]),
    .pos_y       (s_axis_tdata[35:28]),
    .rotation    (s_axis_tdata[36]),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_ready   (m_axis_tready),
    .out_free    (out_free),
    .out_valid   (m_axis_tvalid),
    .kind        (m_axis_tuser),
    .reg_address (reg_address),
    .reg_value   (reg_value),
    .pixels      (pixels),
    .last        (m_axis_tlast)
  );

  assign s_axis_tready = ctl.ready;
  assign m_axis_tdata  = {pixels, reg_value, reg_address};

  // tlast only closes a run of pixel rows
  a_last_on_row: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_ROW)
    else $error("tlast on a result that is not a pixel row");

  // When idle, only the final row of the previous character may be pending
  a_idle_pending: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    else $error("idle while a draw sequence is incomplete");

  // A draw occupies the sequencer; a load does not
  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_DRAW |=> !s_axis_tready)
    else $error("draw accepted without starting the sequence");

  a_load_one: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_LOAD |=> s_axis_tready)
    else $error("font load did not complete in one cycle");

endmodule

`default_nettype wire
